// File: sv/tppc_pkg.sv
// ----------------------------------------------------------------------------
// tppc_pkg
// Shared types and constants of the three-phase power calculator.
// ----------------------------------------------------------------------------
package tppc_pkg;

    localparam int VOLT_W  = 20;
    localparam int CUR_W   = 24;
    localparam int POWER_W = 40;
    localparam int PF_W    = 16;

    localparam int SQ3_W = 19;
    localparam logic [SQ3_W-1:0] SQRT3_Q18 = 19'd454047;
    localparam logic [PF_W-1:0]  PF_ONE    = 16'd32768;
    localparam logic [CUR_W-1:0] CUR_MAX   = 24'hFFFFFF;

    // divider: dividend is the power shifted up by 41, divisor sqrt3*U*pf
    localparam int DIV_SHIFT = 41;
    localparam int REM_W     = POWER_W + DIV_SHIFT;
    localparam int DVS_W     = SQ3_W + VOLT_W + PF_W;
    localparam int NUM_CELLS = CUR_W + 1;

    // square root of 2^30 - pf^2
    localparam int RAD_W      = 31;
    localparam int SQRT_STEPS = 16;

    typedef struct packed {
        logic                cmd;
        logic [VOLT_W-1:0]   voltage;
        logic [CUR_W-1:0]    line_current;
        logic [POWER_W-1:0]  active_power_in;
        logic [PF_W-1:0]     power_factor;
    } in_t;

    typedef struct packed {
        logic                status;
        logic [POWER_W-1:0]  apparent_power;
        logic [POWER_W-1:0]  active_power;
        logic [POWER_W-1:0]  reactive_power;
        logic [PF_W-1:0]     power_factor_out;
        logic [CUR_W-1:0]    line_current_out;
    } out_t;

    // item as it moves through the cell chain
    typedef struct packed {
        logic                bad;
        logic                cmd;
        logic [VOLT_W-1:0]   voltage;
        logic [CUR_W-1:0]    line_current;
        logic [PF_W-1:0]     pf;
        logic [REM_W-1:0]    rem;
        logic [DVS_W-1:0]    dvs;
        logic [CUR_W-1:0]    quo;
        logic                sat;
        logic [RAD_W-1:0]    rad;
        logic [RAD_W-1:0]    root;
    } work_t;

endpackage

// File: sv/tppc_cell.sv
// ----------------------------------------------------------------------------
// tppc_cell
// One pipeline cell: one restoring-division step and, in the first SQRT_STEPS cells, one square-root step.
// ----------------------------------------------------------------------------
module tppc_cell
    import tppc_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output work_t out_data
);

    localparam int  DSH      = NUM_CELLS - 1 - STEP;
    localparam bit  HAS_SQRT = (STEP < SQRT_STEPS);
    localparam int  SJ       = HAS_SQRT ? 2 * (SQRT_STEPS - 1 - STEP) : 0;

    logic             valid_reg;
    work_t            data_reg;
    work_t            data_next;
    logic [REM_W-1:0] dsh;
    logic [RAD_W:0]   trial;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb begin
        data_next = in_data;
        dsh = REM_W'(in_data.dvs) << DSH;
        if (in_data.rem >= dsh) begin
            data_next.rem = in_data.rem - dsh;
            if (DSH == CUR_W) begin
                data_next.sat = 1'b1;
            end else begin
                data_next.quo = in_data.quo | (CUR_W'(1) << DSH);
            end
        end
        trial = {1'b0, in_data.root} + ((RAD_W+1)'(1) << SJ);
        if (HAS_SQRT) begin
            if ({1'b0, in_data.rad} >= trial) begin
                data_next.rad  = in_data.rad - trial[RAD_W-1:0];
                data_next.root = (in_data.root >> 1) + (RAD_W'(1) << SJ);
            end else begin
                data_next.root = in_data.root >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

endmodule

// File: sv/tppc_tail.sv
// ----------------------------------------------------------------------------
// tppc_tail
// Rounding of quotient and root, then S, P and Q multiply stages.
// ----------------------------------------------------------------------------
module tppc_tail
    import tppc_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  work_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output out_t  out_data
);

    localparam int NST  = 5;
    localparam int UC_W = VOLT_W + CUR_W;
    localparam int UI_W = UC_W + SQ3_W;
    localparam int S_W  = UI_W - 25;

    logic [NST-1:0] valid_reg;
    logic [NST-1:0] en;

    logic              bad0_reg, bad1_reg, bad2_reg, bad3_reg;
    logic [VOLT_W-1:0] u0_reg;
    logic [PF_W-1:0]   pf0_reg, pf1_reg, pf2_reg, pf3_reg;
    logic [PF_W-1:0]   sn0_reg, sn1_reg, sn2_reg, sn3_reg;
    logic [CUR_W-1:0]  cur0_reg, cur1_reg, cur2_reg, cur3_reg;
    logic [UC_W-1:0]   uc1_reg;
    logic [UI_W-1:0]   ui2_reg;
    logic [S_W-1:0]    s3_reg;
    out_t              out_reg;

    logic              rnd;
    logic [CUR_W:0]    qsum;
    logic [CUR_W-1:0]  cur_next;
    logic [PF_W-1:0]   sn_next;
    logic [UI_W-1:0]   s_sum;
    logic [S_W+PF_W-1:0] p_prod, q_prod;
    out_t              out_next;

    always_comb begin
        for (int i = 0; i < NST - 1; i++) begin
            en[i] = !valid_reg[i] || en[i+1];
        end
        en[NST-1] = !valid_reg[NST-1] || out_ready;
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[NST-1];
    assign out_data  = out_reg;

    always_comb begin
        rnd  = {in_data.rem[DVS_W-1:0], 1'b0} >= {1'b0, in_data.dvs};
        qsum = {1'b0, in_data.quo} + (CUR_W+1)'(rnd);
        if (!in_data.cmd) begin
            cur_next = in_data.line_current;
        end else if (in_data.sat || qsum[CUR_W]) begin
            cur_next = CUR_MAX;
        end else begin
            cur_next = qsum[CUR_W-1:0];
        end
        sn_next = in_data.root[PF_W-1:0] + PF_W'(in_data.rad > in_data.root);

        s_sum  = ui2_reg + (UI_W'(1) << 25);
        p_prod = s3_reg * pf3_reg + (S_W+PF_W)'(1 << 14);
        q_prod = s3_reg * sn3_reg + (S_W+PF_W)'(1 << 14);

        out_next = '0;
        if (bad3_reg) begin
            out_next.status = 1'b1;
        end else begin
            out_next.apparent_power   = POWER_W'(s3_reg);
            out_next.active_power     = POWER_W'(p_prod >> 15);
            out_next.reactive_power   = POWER_W'(q_prod >> 15);
            out_next.power_factor_out = pf3_reg;
            out_next.line_current_out = cur3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++) begin
                if (en[i]) begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
        if (en[0]) begin
            bad0_reg <= in_data.bad;
            u0_reg   <= in_data.voltage;
            pf0_reg  <= in_data.pf;
            sn0_reg  <= sn_next;
            cur0_reg <= cur_next;
        end
        if (en[1]) begin
            bad1_reg <= bad0_reg;
            pf1_reg  <= pf0_reg;
            sn1_reg  <= sn0_reg;
            cur1_reg <= cur0_reg;
            uc1_reg  <= u0_reg * cur0_reg;
        end
        if (en[2]) begin
            bad2_reg <= bad1_reg;
            pf2_reg  <= pf1_reg;
            sn2_reg  <= sn1_reg;
            cur2_reg <= cur1_reg;
            ui2_reg  <= uc1_reg * SQRT3_Q18;
        end
        if (en[3]) begin
            bad3_reg <= bad2_reg;
            pf3_reg  <= pf2_reg;
            sn3_reg  <= sn2_reg;
            cur3_reg <= cur2_reg;
            s3_reg   <= S_W'(s_sum >> 26);
        end
        if (en[4]) begin
            out_reg <= out_next;
        end
    end

`ifndef ASSERT_OFF
    a_p_le_s: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_data.active_power <= out_data.apparent_power)
        else $error("active power above apparent power");
    a_q_le_s: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> out_data.reactive_power <= out_data.apparent_power)
        else $error("reactive power above apparent power");
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
        else $error("stalled result changed or dropped");
`endif

endmodule

// File: sv/three_phase_power_calc.sv
// ----------------------------------------------------------------------------
// three_phase_power_calc
// Balanced three-phase S, P and Q calculator with current derivation.
// ----------------------------------------------------------------------------
// Fully pipelined: one item per cycle while the output is not stalled, through 32
// register stages (two front stages forming sqrt3*U*pf and 1 - pf^2, a chain of
// 25 cells each doing one quotient bit and, in the first 16, one root bit, then
// five stages for rounding and the S, P and Q multiplies). Every stage holds its
// item when the next one is full, so bubbles are squeezed out and input
// transfers continue while a result waits at the output, until the pipeline
// is full.
module three_phase_power_calc
    import tppc_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic          p0_valid_reg, p1_valid_reg;
    logic          p0_en, p1_en;
    in_t           p0_data_reg;
    logic          p0_bad_reg;
    logic [VOLT_W+PF_W-1:0] p0_upf_reg;
    logic [2*PF_W-1:0]      p0_pf2_reg;
    work_t         p1_data_reg;
    logic          bad_next;

    logic  [NUM_CELLS:0] c_valid;
    logic  [NUM_CELLS:0] c_ready;
    work_t c_data [NUM_CELLS+1];

    assign p1_en   = !p1_valid_reg || c_ready[0];
    assign p0_en   = !p0_valid_reg || p1_en;
    assign s_ready = p0_en;

    always_comb begin
        bad_next = (s_data.voltage == '0) || (s_data.power_factor > PF_ONE) ||
                   (s_data.cmd && ((s_data.active_power_in == '0) ||
                                   (s_data.power_factor == '0)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_valid_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (p0_en) p0_valid_reg <= s_valid;
            if (p1_en) p1_valid_reg <= p0_valid_reg;
        end
        if (p0_en) begin
            p0_data_reg <= s_data;
            p0_bad_reg  <= bad_next;
            p0_upf_reg  <= s_data.voltage * s_data.power_factor;
            p0_pf2_reg  <= s_data.power_factor * s_data.power_factor;
        end
        if (p1_en) begin
            p1_data_reg.bad          <= p0_bad_reg;
            p1_data_reg.cmd          <= p0_data_reg.cmd;
            p1_data_reg.voltage      <= p0_data_reg.voltage;
            p1_data_reg.line_current <= p0_data_reg.line_current;
            p1_data_reg.pf           <= p0_data_reg.power_factor;
            p1_data_reg.rem  <= {p0_data_reg.active_power_in, DIV_SHIFT'(0)};
            p1_data_reg.dvs  <= DVS_W'(p0_upf_reg) * DVS_W'(SQRT3_Q18);
            p1_data_reg.quo  <= '0;
            p1_data_reg.sat  <= 1'b0;
            p1_data_reg.rad  <= RAD_W'((2*PF_W+1)'(1 << 30) - (2*PF_W+1)'(p0_pf2_reg));
            p1_data_reg.root <= '0;
        end
    end

    assign c_valid[0] = p1_valid_reg;
    assign c_data[0]  = p1_data_reg;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        tppc_cell #(.STEP(g)) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[g]),
            .in_ready  (c_ready[g]),
            .in_data   (c_data[g]),
            .out_valid (c_valid[g+1]),
            .out_ready (c_ready[g+1]),
            .out_data  (c_data[g+1])
        );
    end

    tppc_tail u_tail (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid[NUM_CELLS]),
        .in_ready  (c_ready[NUM_CELLS]),
        .in_data   (c_data[NUM_CELLS]),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (m_data)
    );

`ifndef ASSERT_OFF
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.status) |->
            (m_data.apparent_power == '0 && m_data.line_current_out == '0 &&
             m_data.power_factor_out == '0))
        else $error("invalid result carries nonzero fields");
    a_pf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.status) |-> m_data.power_factor_out <= PF_ONE)
        else $error("valid result with power factor above one");
    a_front_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (p1_valid_reg && !c_ready[0]) |=> (p1_valid_reg && $stable(p1_data_reg)))
        else $error("front stage dropped a stalled item");
`endif

endmodule

// File: verif/tppc_checker.sv
// ----------------------------------------------------------------------------
// tppc_checker
// Watches both channels of the power calculator, predicts each result from
// the accepted input and compares it as a whole with what comes out.
// ----------------------------------------------------------------------------
module tppc_checker
    import tppc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_t         s_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_t        m_data,
    output int          fail_count,
    output int          pending_count,
    output int          result_count
);

    out_t expected_q[$];

    // rounded integer square root
    function automatic logic [63:0] root_round(input logic [63:0] n);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        if (n > r) r = r + 1;
        return r;
    endfunction

    // current from power: round(p * 2^41 / (sqrt3*U*pf)), saturated
    function automatic logic [CUR_W-1:0] current_from_power(
        input logic [POWER_W-1:0] p, input logic [VOLT_W-1:0] u,
        input logic [PF_W-1:0] pf);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] quo;
        logic [127:0] rem;
        num = {88'd0, p} << 41;
        den = 128'(SQRT3_Q18) * 128'(u) * 128'(pf);
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem) quo = quo + 1;
        if (quo > 128'(CUR_MAX)) return CUR_MAX;
        return quo[CUR_W-1:0];
    endfunction

    function automatic out_t power_result(input in_t d);
        out_t o;
        logic [CUR_W-1:0] cur;
        logic [127:0] s;
        logic [127:0] p;
        logic [127:0] q;
        logic [63:0]  sn;
        o = '0;
        if (d.voltage == 0 || d.power_factor > PF_ONE ||
            (d.cmd && (d.active_power_in == 0 || d.power_factor == 0))) begin
            o.status = 1'b1;
            return o;
        end
        cur = d.cmd ? current_from_power(d.active_power_in, d.voltage, d.power_factor)
                    : d.line_current;
        s  = (128'(d.voltage) * 128'(cur) * 128'(SQRT3_Q18) + (128'd1 << 25)) >> 26;
        p  = (s * 128'(d.power_factor) + (128'd1 << 14)) >> 15;
        sn = root_round((64'd1 << 30) - 64'(d.power_factor) * 64'(d.power_factor));
        q  = (s * 128'(sn) + (128'd1 << 14)) >> 15;
        o.apparent_power   = s[POWER_W-1:0];
        o.active_power     = p[POWER_W-1:0];
        o.reactive_power   = q[POWER_W-1:0];
        o.power_factor_out = d.power_factor;
        o.line_current_out = cur;
        return o;
    endfunction

    assign pending_count = expected_q.size();

    always @(posedge aclk) begin
        out_t e;
        if (!aresetn) begin
            fail_count   <= 0;
            result_count <= 0;
        end else begin
            if (s_valid && s_ready) expected_q.push_back(power_result(s_data));
            if (m_valid && m_ready) begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer: %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e !== m_data) begin
                        if (fail_count < 10)
                            $display("result mismatch: expected %p, got %p", e, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives the power calculator with directed corner cases and random
// measurements under random stalls on both channels; the checker judges.
// ----------------------------------------------------------------------------
module tb_top;
    import tppc_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_t  s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_t m_data;
    int   fail_count;
    int   pending_count;
    int   result_count;
    int   sent_count = 0;
    bit   stim_done = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    three_phase_power_calc u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    tppc_checker u_checker (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .fail_count(fail_count), .pending_count(pending_count),
        .result_count(result_count)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic in_t random_item();
        in_t d;
        int  k;
        d.cmd             = 1'($urandom_range(0, 1));
        d.voltage         = VOLT_W'($urandom);
        d.line_current    = CUR_W'($urandom);
        d.active_power_in = POWER_W'({$urandom, $urandom});
        d.power_factor    = PF_W'($urandom_range(0, 32768));
        k = $urandom_range(0, 19);
        // mostly realistic values, some with small magnitudes or invalid fields
        if (k == 0) d.voltage = 0;
        if (k == 1) d.power_factor = PF_W'($urandom);
        if (k == 2) d.active_power_in = 0;
        if (k == 3) d.power_factor = 0;
        if (k == 4) d.voltage = VOLT_W'($urandom_range(1, 255));
        if (k == 5) d.active_power_in = POWER_W'($urandom_range(1, 4095));
        if (k == 6) d.line_current = CUR_W'($urandom_range(0, 255));
        if (k == 7) d.power_factor = PF_ONE;
        if (k == 8) d.voltage = {VOLT_W{1'b1}};
        if (k == 9) d.active_power_in = d.active_power_in >> $urandom_range(0, 30);
        return d;
    endfunction

    // hold the item until accepted, then idle for a random gap, which may be empty
    task automatic send_item(input in_t d);
        int g;
        s_valid <= 1'b1;
        s_data  <= d;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_count++;
        g = gap_len();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
    endtask

    function automatic in_t make_item(input logic c, input logic [VOLT_W-1:0] u,
        input logic [CUR_W-1:0] i, input logic [POWER_W-1:0] p,
        input logic [PF_W-1:0] pf);
        in_t d;
        d.cmd = c; d.voltage = u; d.line_current = i;
        d.active_power_in = p; d.power_factor = pf;
        return d;
    endfunction

    // result side stalls, with calm stretches
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if ($urandom_range(0, 499) < 5) m_ready <= 1'b0;
        else if (!m_ready) m_ready <= ($urandom_range(0, 3) == 0);
        else m_ready <= ($urandom_range(0, 9) != 0) || (result_count % 400 > 300);
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        send_item(make_item(0, 0, 1000, 0, 16384));
        send_item(make_item(0, 1000, 1000, 0, 32769));
        send_item(make_item(0, 1000, 1000, 0, 16'hFFFF));
        send_item(make_item(1, 1000, 0, 0, 16384));
        send_item(make_item(1, 1000, 0, 1000, 0));
        send_item(make_item(0, {VOLT_W{1'b1}}, {CUR_W{1'b1}}, '1, PF_ONE));
        send_item(make_item(0, {VOLT_W{1'b1}}, {CUR_W{1'b1}}, 0, 0));
        send_item(make_item(0, 1, 0, 0, 1));
        send_item(make_item(0, 3680, 2560, 0, 27853));
        send_item(make_item(1, 1, 0, {POWER_W{1'b1}}, 1));
        send_item(make_item(1, 1, {CUR_W{1'b1}}, 1, PF_ONE));
        send_item(make_item(1, {VOLT_W{1'b1}}, 0, 1, PF_ONE));
        send_item(make_item(1, 6080, 0, 40'd160000, 29491));
        send_item(make_item(1, 6080, 24'hABCDEF, 40'd160000, 29491));
        send_item(make_item(1, {VOLT_W{1'b1}}, 0, {POWER_W{1'b1}}, PF_ONE));
        send_item(make_item(0, 4000, 24'h800000, 40'hFFFFFFFFFF, 1));
        repeat (1800) send_item(random_item());
        s_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending_count != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("sent %0d measurements (corner cases and random), checked %0d results",
                 sent_count, result_count);
        if (fail_count == 0 && pending_count == 0) $display("tb_top passed");
        else $display("tb_top failed");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

endmodule

// File: files.f
sv/tppc_pkg.sv
sv/tppc_cell.sv
sv/tppc_tail.sv
sv/three_phase_power_calc.sv
verif/tppc_checker.sv
verif/tb_top.sv
